// File: rtl/pvc_pkg.sv
package pvc_pkg;

    localparam int MAX_CHARS       = 256;
    localparam int MAX_EXPRESSIONS = 8;
    localparam int STACK_DEPTH     = 32;
    localparam int MAX_VARIABLES   = 12;
    localparam int NUM_LETTERS     = 52;

    localparam int CHAR_AW = $clog2(MAX_CHARS);
    localparam int CNT_W   = $clog2(MAX_CHARS + 1);
    localparam int EXP_AW  = (MAX_EXPRESSIONS > 1) ? $clog2(MAX_EXPRESSIONS) : 1;
    localparam int EXP_W   = $clog2(MAX_EXPRESSIONS + 1);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int VAR_W   = 6;

    typedef logic [2:0] t_op;

    localparam t_op OP_BICOND = 3'd0;
    localparam t_op OP_IMPL   = 3'd1;
    localparam t_op OP_OR     = 3'd2;
    localparam t_op OP_AND    = 3'd3;
    localparam t_op OP_NOT    = 3'd4;
    localparam t_op OP_OPEN   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_CAPACITY  = 3'd4;

    typedef struct packed {
        logic clear;
        logic push_val;
        logic val;
        logic push_op;
        t_op  op;
        logic pop;
        logic drop;
    } t_stk_cmd;

    typedef struct packed {
        logic [SP_W-1:0] vsp;
        logic [SP_W-1:0] osp;
        logic            vtop;
        t_op             otop;
    } t_stk_st;

    function automatic logic apply_op(t_op op, logic a, logic b);
        logic r;
        case (op)
            OP_NOT:    r = ~a;
            OP_AND:    r = a & b;
            OP_OR:     r = a | b;
            OP_IMPL:   r = ~a | b;
            OP_BICOND: r = (a == b);
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // {is_letter, index}: A-Z -> 0..25, a-z -> 26..51
    function automatic logic [VAR_W:0] letter_index(logic [7:0] c);
        logic [VAR_W:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, VAR_W'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, VAR_W'(c - 8'h61 + 8'd26)};
        end
        return r;
    endfunction

endpackage

// File: rtl/pvc_char_mem.sv
module pvc_char_mem
    import pvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [CHAR_AW-1:0] i_waddr,
    input  logic [7:0]         i_wdata,
    input  logic               i_re,
    input  logic [CHAR_AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [MAX_CHARS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pvc_stack_unit.sv
module pvc_stack_unit
    import pvc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_stk_cmd i_cmd,
    output t_stk_st  o_st
);

    logic [STACK_DEPTH-1:0] r_vstk;
    logic [STACK_DEPTH-1:0] n_vstk;
    t_op                    r_ostk [STACK_DEPTH];
    t_op                    n_ostk [STACK_DEPTH];
    logic [SP_W-1:0]        r_vsp;
    logic [SP_W-1:0]        n_vsp;
    logic [SP_W-1:0]        r_osp;
    logic [SP_W-1:0]        n_osp;

    always_comb begin
        n_vstk = r_vstk;
        n_ostk = r_ostk;
        n_vsp  = r_vsp;
        n_osp  = r_osp;
        if (i_cmd.clear) begin
            n_vsp = '0;
            n_osp = '0;
        end else if (i_cmd.push_val) begin
            n_vstk = {r_vstk[STACK_DEPTH-2:0], i_cmd.val};
            n_vsp  = r_vsp + 1'b1;
        end else if (i_cmd.push_op) begin
            for (int k = 1; k < STACK_DEPTH; k++) begin
                n_ostk[k] = r_ostk[k-1];
            end
            n_ostk[0] = i_cmd.op;
            n_osp     = r_osp + 1'b1;
        end else if (i_cmd.pop || i_cmd.drop) begin
            for (int k = 0; k < STACK_DEPTH - 1; k++) begin
                n_ostk[k] = r_ostk[k+1];
            end
            n_osp = r_osp - 1'b1;
            if (i_cmd.pop) begin
                if (r_ostk[0] == OP_NOT) begin
                    n_vstk[0] = apply_op(OP_NOT, r_vstk[0], 1'b0);
                end else begin
                    // top is the right operand, the one below the left
                    for (int k = 1; k < STACK_DEPTH - 1; k++) begin
                        n_vstk[k] = r_vstk[k+1];
                    end
                    n_vstk[0] = apply_op(r_ostk[0], r_vstk[1], r_vstk[0]);
                    n_vsp     = r_vsp - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsp <= '0;
            r_osp <= '0;
        end else begin
            r_vsp <= n_vsp;
            r_osp <= n_osp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vstk <= n_vstk;
        r_ostk <= n_ostk;
    end

    assign o_st.vsp  = r_vsp;
    assign o_st.osp  = r_osp;
    assign o_st.vtop = r_vstk[0];
    assign o_st.otop = r_ostk[0];

endmodule

// File: rtl/propositional_validity_checker.sv
// Channel   Signals                                              Direction
// command   start, busy (out), i_expression_char,                  in
//           i_end_of_expression, i_is_conclusion
// result    o_strobe, o_argument_valid, o_argument_satisfiable,   out
//           o_status, o_variable_count
// Loading accepts one character per cycle; busy stays low while characters stream in.
// The final conclusion character starts the truth table walk, up to 2**variables rows:
// each row has a set-up step; each expression a set-up, end check, drain and close;
// each character a char memory read, then a token step. An operator or ')' first pops
// what it may reduce, then pushes or drops. o_strobe is registered from the done state.
// Synchronous active-low reset; no clearing pass. o_strobe lasts one cycle, no stall.
module propositional_validity_checker
    import pvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [7:0]       i_expression_char,
    input  logic             i_end_of_expression,
    input  logic             i_is_conclusion,
    output logic             o_strobe,
    output logic             o_argument_valid,
    output logic             o_argument_satisfiable,
    output logic [2:0]       o_status,
    output logic [VAR_W-1:0] o_variable_count
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ROW     = 4'd1;
    localparam logic [3:0] S_EXP     = 4'd2;
    localparam logic [3:0] S_FETCH   = 4'd3;
    localparam logic [3:0] S_PROC    = 4'd4;
    localparam logic [3:0] S_REDUCE  = 4'd5;
    localparam logic [3:0] S_CLOSE   = 4'd6;
    localparam logic [3:0] S_FINAL   = 4'd7;
    localparam logic [3:0] S_EXPDONE = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    localparam logic [1:0] RET_FETCH = 2'd0;
    localparam logic [1:0] RET_PROC  = 2'd1;
    localparam logic [1:0] RET_FINAL = 2'd2;

    logic [3:0]             r_state,   n_state;
    logic [CNT_W-1:0]       r_ctot,    n_ctot;
    logic [EXP_W-1:0]       r_etot,    n_etot;
    logic [NUM_LETTERS-1:0] r_seen,    n_seen;
    logic [VAR_W-1:0]       r_nvars,   n_nvars;
    logic [2:0]             r_err,     n_err;
    logic                   r_valid,   n_valid;
    logic                   r_sat,     n_sat;
    logic [NUM_LETTERS-1:0] r_assign,  n_assign;
    logic [EXP_W-1:0]       r_exp,     n_exp;
    logic [CNT_W-1:0]       r_start,   n_start;
    logic [CNT_W-1:0]       r_end,     n_end;
    logic [CNT_W-1:0]       r_ptr,     n_ptr;
    logic                   r_all,     n_all;
    logic                   r_res,     n_res;
    logic                   r_gt,      n_gt;
    logic                   r_lt,      n_lt;
    logic                   r_ltm,     n_ltm;
    t_op                    r_prec,    n_prec;
    logic [1:0]             r_ret,     n_ret;
    logic                   r_strobe,  n_strobe;
    logic                   r_ovalid,  n_ovalid;
    logic                   r_osat,    n_osat;
    logic [2:0]             r_ostat,   n_ostat;
    logic [VAR_W-1:0]       r_ovars,   n_ovars;

    logic [CNT_W-1:0]       r_ends [MAX_EXPRESSIONS];

    logic                   accept;
    logic                   mem_we;
    logic                   mem_re;
    logic [7:0]             mem_rdata;
    logic                   ends_we;
    t_stk_cmd               stk_cmd;
    t_stk_st                stk_st;
    logic [VAR_W:0]         in_li;
    logic [VAR_W:0]         rd_li;
    logic                   pop_ok;
    logic                   can_reduce;
    logic                   last_exp;
    logic                   new_valid;
    logic                   new_sat;
    logic [NUM_LETTERS:0]   next_row;
    logic                   is_space;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign in_li  = letter_index(i_expression_char);
    assign rd_li  = letter_index(mem_rdata);
    assign pop_ok = (stk_st.otop == OP_NOT) ? (stk_st.vsp != '0)
                                            : (stk_st.vsp >= SP_W'(2));
    assign can_reduce = (stk_st.osp != '0) && (stk_st.otop != OP_OPEN)
                        && (stk_st.otop >= r_prec);
    assign last_exp = (r_exp == r_etot - 1'b1);
    assign is_space = (mem_rdata == 8'h20) || (mem_rdata >= 8'h09 && mem_rdata <= 8'h0D);
    // next assignment: ripple the carry only through letters that occur
    assign next_row = {1'b0, r_assign | ~r_seen} + 1'b1;

    pvc_char_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ctot[CHAR_AW-1:0]),
        .i_wdata (i_expression_char),
        .i_re    (mem_re),
        .i_raddr (r_ptr[CHAR_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    pvc_stack_unit u_stk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stk_cmd),
        .o_st    (stk_st)
    );

    always_comb begin
        n_state  = r_state;
        n_ctot   = r_ctot;
        n_etot   = r_etot;
        n_seen   = r_seen;
        n_nvars  = r_nvars;
        n_err    = r_err;
        n_valid  = r_valid;
        n_sat    = r_sat;
        n_assign = r_assign;
        n_exp    = r_exp;
        n_start  = r_start;
        n_end    = r_end;
        n_ptr    = r_ptr;
        n_all    = r_all;
        n_res    = r_res;
        n_gt     = r_gt;
        n_lt     = r_lt;
        n_ltm    = r_ltm;
        n_prec   = r_prec;
        n_ret    = r_ret;
        n_strobe = 1'b0;
        n_ovalid = r_ovalid;
        n_osat   = r_osat;
        n_ostat  = r_ostat;
        n_ovars  = r_ovars;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        ends_we  = 1'b0;
        stk_cmd  = '0;
        new_valid = r_valid;
        new_sat   = r_sat;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_ctot < CNT_W'(MAX_CHARS)) begin
                        mem_we = 1'b1;
                        n_ctot = r_ctot + 1'b1;
                        if (in_li[VAR_W] && !r_seen[in_li[VAR_W-1:0]]) begin
                            n_seen[in_li[VAR_W-1:0]] = 1'b1;
                            n_nvars = r_nvars + 1'b1;
                        end
                    end else begin
                        n_err = ST_CAPACITY;
                    end
                    if (i_end_of_expression) begin
                        if (r_etot < EXP_W'(MAX_EXPRESSIONS)) begin
                            ends_we = 1'b1;
                            n_etot  = r_etot + 1'b1;
                        end else begin
                            n_err = ST_CAPACITY;
                        end
                        if (i_is_conclusion) begin
                            n_assign = '0;
                            if (n_err != ST_OK) begin
                                n_state = S_DONE;
                            end else if (n_nvars > VAR_W'(MAX_VARIABLES)) begin
                                n_err   = ST_TOO_MANY;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ROW;
                            end
                        end
                    end
                end
            end
            S_ROW: begin
                n_exp   = '0;
                n_start = '0;
                n_all   = 1'b1;
                n_state = S_EXP;
            end
            S_EXP: begin
                n_end   = r_ends[r_exp[EXP_AW-1:0]];
                n_ptr   = r_start;
                n_gt    = 1'b0;
                n_lt    = 1'b0;
                n_ltm   = 1'b0;
                stk_cmd.clear = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_ptr == r_end) begin
                    if (r_ltm) begin
                        // "<-" at the end: the dash is a lone implication
                        n_ltm   = 1'b0;
                        n_prec  = OP_IMPL;
                        n_ret   = RET_FINAL;
                        n_state = S_REDUCE;
                    end else begin
                        n_state = S_FINAL;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                n_state = S_FETCH;
                if (r_ltm) begin
                    n_ltm = 1'b0;
                    if (mem_rdata != 8'h3E) begin
                        // no "<->": dash acts alone, then this char again
                        n_prec  = OP_IMPL;
                        n_ret   = RET_PROC;
                        n_state = S_REDUCE;
                    end
                end else if (r_gt && mem_rdata == 8'h3E) begin
                    n_gt = 1'b0;
                end else if (r_lt && mem_rdata == 8'h2D) begin
                    n_lt  = 1'b0;
                    n_ltm = 1'b1;
                end else begin
                    n_gt = 1'b0;
                    n_lt = 1'b0;
                    n_ret = RET_FETCH;
                    if (is_space) begin
                        n_state = S_FETCH;
                    end else if (rd_li[VAR_W]) begin
                        if (stk_st.vsp >= SP_W'(STACK_DEPTH)) begin
                            n_err   = ST_CAPACITY;
                            n_state = S_DONE;
                        end else begin
                            stk_cmd.push_val = 1'b1;
                            stk_cmd.val      = r_assign[rd_li[VAR_W-1:0]];
                        end
                    end else if (mem_rdata == 8'h28) begin
                        if (stk_st.osp >= SP_W'(STACK_DEPTH)) begin
                            n_err   = ST_CAPACITY;
                            n_state = S_DONE;
                        end else begin
                            stk_cmd.push_op = 1'b1;
                            stk_cmd.op      = OP_OPEN;
                        end
                    end else if (mem_rdata == 8'h29) begin
                        n_state = S_CLOSE;
                    end else if (mem_rdata == 8'h7E) begin
                        n_prec  = OP_NOT;
                        n_state = S_REDUCE;
                    end else if (mem_rdata == 8'h26) begin
                        n_prec  = OP_AND;
                        n_state = S_REDUCE;
                    end else if (mem_rdata == 8'h7C) begin
                        n_prec  = OP_OR;
                        n_state = S_REDUCE;
                    end else if (mem_rdata == 8'h2D) begin
                        n_prec  = OP_IMPL;
                        n_gt    = 1'b1;
                        n_state = S_REDUCE;
                    end else if (mem_rdata == 8'h3C) begin
                        n_prec  = OP_BICOND;
                        n_lt    = 1'b1;
                        n_state = S_REDUCE;
                    end else begin
                        n_err   = ST_BAD_CHAR;
                        n_state = S_DONE;
                    end
                end
            end
            S_REDUCE: begin
                if (can_reduce) begin
                    if (pop_ok) begin
                        stk_cmd.pop = 1'b1;
                    end else begin
                        n_err   = ST_MALFORMED;
                        n_state = S_DONE;
                    end
                end else if (stk_st.osp >= SP_W'(STACK_DEPTH)) begin
                    n_err   = ST_CAPACITY;
                    n_state = S_DONE;
                end else begin
                    stk_cmd.push_op = 1'b1;
                    stk_cmd.op      = r_prec;
                    case (r_ret)
                        RET_PROC:  n_state = S_PROC;
                        RET_FINAL: n_state = S_FINAL;
                        default:   n_state = S_FETCH;
                    endcase
                end
            end
            S_CLOSE: begin
                if (stk_st.osp != '0 && stk_st.otop != OP_OPEN) begin
                    if (pop_ok) begin
                        stk_cmd.pop = 1'b1;
                    end else begin
                        n_err   = ST_MALFORMED;
                        n_state = S_DONE;
                    end
                end else begin
                    if (stk_st.osp != '0) begin
                        stk_cmd.drop = 1'b1;
                    end
                    n_state = S_FETCH;
                end
            end
            S_FINAL: begin
                // a leftover '(' pops like a binary op yielding false
                if (stk_st.osp != '0) begin
                    if (pop_ok) begin
                        stk_cmd.pop = 1'b1;
                    end else begin
                        n_err   = ST_MALFORMED;
                        n_state = S_DONE;
                    end
                end else begin
                    n_res   = (stk_st.vsp != '0) && stk_st.vtop;
                    n_state = S_EXPDONE;
                end
            end
            S_EXPDONE: begin
                if (last_exp) begin
                    if (r_all) begin
                        if (r_res) begin
                            new_sat = 1'b1;
                        end else begin
                            new_valid = 1'b0;
                        end
                    end
                    n_valid = new_valid;
                    n_sat   = new_sat;
                    if ((!new_valid && new_sat) || (r_assign == r_seen)) begin
                        n_state = S_DONE;
                    end else begin
                        n_assign = next_row[NUM_LETTERS-1:0] & r_seen;
                        n_state  = S_ROW;
                    end
                end else begin
                    n_all   = r_all & r_res;
                    n_start = r_end;
                    n_exp   = r_exp + 1'b1;
                    n_state = S_EXP;
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_ovalid = (r_err == ST_OK) && r_valid;
                n_osat   = (r_err == ST_OK) && r_sat;
                n_ostat  = r_err;
                n_ovars  = r_nvars;
                n_ctot   = '0;
                n_etot   = '0;
                n_seen   = '0;
                n_nvars  = '0;
                n_err    = ST_OK;
                n_valid  = 1'b1;
                n_sat    = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctot   <= '0;
            r_etot   <= '0;
            r_seen   <= '0;
            r_nvars  <= '0;
            r_err    <= ST_OK;
            r_valid  <= 1'b1;
            r_sat    <= 1'b0;
            r_assign <= '0;
            r_exp    <= '0;
            r_gt     <= 1'b0;
            r_lt     <= 1'b0;
            r_ltm    <= 1'b0;
            r_ret    <= RET_FETCH;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ctot   <= n_ctot;
            r_etot   <= n_etot;
            r_seen   <= n_seen;
            r_nvars  <= n_nvars;
            r_err    <= n_err;
            r_valid  <= n_valid;
            r_sat    <= n_sat;
            r_assign <= n_assign;
            r_exp    <= n_exp;
            r_gt     <= n_gt;
            r_lt     <= n_lt;
            r_ltm    <= n_ltm;
            r_ret    <= n_ret;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_end    <= n_end;
        r_ptr    <= n_ptr;
        r_all    <= n_all;
        r_res    <= n_res;
        r_prec   <= n_prec;
        r_ovalid <= n_ovalid;
        r_osat   <= n_osat;
        r_ostat  <= n_ostat;
        r_ovars  <= n_ovars;
        if (ends_we) begin
            r_ends[r_etot[EXP_AW-1:0]] <= n_ctot;
        end
    end

    assign o_strobe               = r_strobe;
    assign o_argument_valid       = r_ovalid;
    assign o_argument_satisfiable = r_osat;
    assign o_status               = r_ostat;
    assign o_variable_count       = r_ovars;

endmodule
